@@ rtl/core/color_blob_centroid_core_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the blob centroid core.
// Both macros use the clk and arst_n of the module that expands them.
// ---------------------------------------------------------------------------
`ifndef COLOR_BLOB_CENTROID_CORE_MACROS_SVH
`define COLOR_BLOB_CENTROID_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset
`define CBC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset
`define CBC_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/cbc_pkg.sv @@
// ---------------------------------------------------------------------------
// cbc_pkg
// Shared types and constants of the blob centroid core.
// ---------------------------------------------------------------------------
package cbc_pkg;

	// Field widths
	localparam int COORD_W = 10;
	localparam int CHAN_W  = 8;
	localparam int RATIO_W = 4;
	localparam int MEAN_W  = 10;
	localparam int COUNT_W = 21;
	localparam int SUM_W   = COUNT_W + MEAN_W - 1;
	localparam int PROD_W  = CHAN_W + RATIO_W;
	localparam int STEP_W  = $clog2(MEAN_W);

	// Image bounds; a pixel outside them never matches
	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;
	localparam int BOUND_W    = 13;

	// Matches past this count are dropped for the rest of the frame
	localparam logic [COUNT_W-1:0] COUNT_CAP = COUNT_W'(1 << 20);

	// Register file
	localparam int                 CFG_ADDR_W   = 3;
	localparam int                 CFG_DATA_W   = 32;
	localparam logic               REG_RATIO    = 1'b0;
	localparam logic [RATIO_W-1:0] RATIO_RESET  = RATIO_W'(5);

	// Frame queue depth default
	localparam int QUEUE_DEPTH_DEF = 2;

	// Per-frame totals handed from front to back
	typedef struct packed {
		logic [SUM_W-1:0]   sum_x;
		logic [SUM_W-1:0]   sum_y;
		logic [COUNT_W-1:0] count;
	} frame_sums_t;

	// Queue status seen by both sides
	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

	// Divider sequencer
	typedef enum logic [1:0] {
		DIV_IDLE,
		DIV_RUN,
		DIV_DONE
	} div_state_t;

endpackage

@@ rtl/core/cbc_ifs.sv @@
// ---------------------------------------------------------------------------
// cbc_pixel_if / cbc_result_if
// Valid/ready channels for pixel words and centroid result words.
// ---------------------------------------------------------------------------
interface cbc_pixel_if;
	import cbc_pkg::*;

	logic               valid;
	logic               ready;
	logic [COORD_W-1:0] column;
	logic [COORD_W-1:0] row;
	logic [CHAN_W-1:0]  red;
	logic [CHAN_W-1:0]  green;
	logic [CHAN_W-1:0]  blue;
	logic               frame_end;

	modport source (output valid, column, row, red, green, blue, frame_end, input ready);
	modport sink   (input valid, column, row, red, green, blue, frame_end, output ready);
endinterface

interface cbc_result_if;
	import cbc_pkg::*;

	logic              valid;
	logic              ready;
	logic              found;
	logic [MEAN_W-1:0] mean_x;
	logic [MEAN_W-1:0] mean_y;

	modport source (output valid, found, mean_x, mean_y, input ready);
	modport sink   (input valid, found, mean_x, mean_y, output ready);
endinterface

@@ rtl/core/cbc_fifo.sv @@
// ---------------------------------------------------------------------------
// cbc_fifo
// Short register queue of per-frame totals between front and back.
// ---------------------------------------------------------------------------
module cbc_fifo #(
	parameter int DEPTH = cbc_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  cbc_pkg::frame_sums_t push_data,
	input  logic                pop,
	output cbc_pkg::frame_sums_t pop_data,
	output cbc_pkg::queue_stat_t stat
);
	import cbc_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	frame_sums_t        entry_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   cnt_q;

	assign stat.full  = (cnt_q == FULL_CNT);
	assign stat.empty = (cnt_q == '0);
	assign pop_data   = entry_q[rd_ptr_q];

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

@@ rtl/core/cbc_front.sv @@
// ---------------------------------------------------------------------------
// cbc_front
// Classifies each pixel by the blue dominance test and accumulates the
// coordinate sums and match count; hands the totals on at frame end.
// ---------------------------------------------------------------------------
module cbc_front (
	input  logic                       clk,
	input  logic                       arst_n,
	cbc_pixel_if.sink                  pixel,
	input  logic [cbc_pkg::RATIO_W-1:0] ratio,
	input  cbc_pkg::queue_stat_t       qstat,
	output logic                       push,
	output cbc_pkg::frame_sums_t       push_data
);
	import cbc_pkg::*;

	localparam logic [BOUND_W-1:0] WIDTH_LIM  = BOUND_W'(MAX_WIDTH);
	localparam logic [BOUND_W-1:0] HEIGHT_LIM = BOUND_W'(MAX_HEIGHT);

	logic [SUM_W-1:0]   sum_x_q;
	logic [SUM_W-1:0]   sum_y_q;
	logic [COUNT_W-1:0] count_q;
	logic [PROD_W-1:0]  prod_r;
	logic [PROD_W-1:0]  prod_g;
	logic               in_bounds;
	logic               is_match;
	logic               take;
	logic               accept;

	// Hold off whole pixel stream while queue has no room for a frame
	assign pixel.ready = !qstat.full;
	assign accept      = pixel.valid && pixel.ready;

	// Dominance test, exact integer compare
	assign prod_r    = PROD_W'(ratio) * PROD_W'(pixel.red);
	assign prod_g    = PROD_W'(ratio) * PROD_W'(pixel.green);
	assign in_bounds = (BOUND_W'(pixel.column) < WIDTH_LIM) &&
	                   (BOUND_W'(pixel.row) < HEIGHT_LIM);
	assign is_match  = in_bounds && (PROD_W'(pixel.blue) > prod_r) &&
	                   (PROD_W'(pixel.blue) > prod_g);
	assign take      = is_match && (count_q < COUNT_CAP);

	// Totals including the current pixel
	always_comb begin
		push_data.sum_x = sum_x_q + (take ? SUM_W'(pixel.column) : '0);
		push_data.sum_y = sum_y_q + (take ? SUM_W'(pixel.row) : '0);
		push_data.count = count_q + (take ? COUNT_W'(1) : '0);
	end

	assign push = accept && pixel.frame_end;

	// Accumulators, cleared after each frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_x_q <= '0;
			sum_y_q <= '0;
			count_q <= '0;
		end else if (accept) begin
			if (pixel.frame_end) begin
				sum_x_q <= '0;
				sum_y_q <= '0;
				count_q <= '0;
			end else begin
				sum_x_q <= push_data.sum_x;
				sum_y_q <= push_data.sum_y;
				count_q <= push_data.count;
			end
		end
	end

endmodule

@@ rtl/core/cbc_divider.sv @@
// ---------------------------------------------------------------------------
// cbc_divider
// Back end: takes frame totals from the queue, divides both sums by the
// count one quotient bit per cycle and holds the result in an output stage.
// ---------------------------------------------------------------------------
`include "color_blob_centroid_core_macros.svh"

module cbc_divider (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cbc_pkg::queue_stat_t qstat,
	input  cbc_pkg::frame_sums_t pop_data,
	output logic                 pop,
	cbc_result_if.source         result
);
	import cbc_pkg::*;

	localparam logic [STEP_W-1:0] TOP_STEP = STEP_W'(MEAN_W - 1);

	div_state_t         state_q;
	div_state_t         state_d;
	logic [SUM_W-1:0]   rem_x_q;
	logic [SUM_W-1:0]   rem_y_q;
	logic [SUM_W-1:0]   dvs_q;
	logic [COUNT_W-1:0] cnt_q;
	logic [MEAN_W-1:0]  qx_q;
	logic [MEAN_W-1:0]  qy_q;
	logic [STEP_W-1:0]  step_q;
	logic               ge_x;
	logic               ge_y;
	logic               load_out;
	logic               nonzero;
	logic               out_valid_q;
	logic               found_q;
	logic [MEAN_W-1:0]  mean_x_q;
	logic [MEAN_W-1:0]  mean_y_q;

	assign ge_x    = (rem_x_q >= dvs_q);
	assign ge_y    = (rem_y_q >= dvs_q);
	assign nonzero = (cnt_q != '0);

	// Sequencer: next state and strobes
	always_comb begin
		state_d  = state_q;
		pop      = 1'b0;
		load_out = 1'b0;
		case (state_q)
			DIV_IDLE: begin
				if (!qstat.empty) begin
					pop     = 1'b1;
					state_d = DIV_RUN;
				end
			end
			DIV_RUN: begin
				if (step_q == '0) begin
					state_d = DIV_DONE;
				end
			end
			DIV_DONE: begin
				if (!out_valid_q || result.ready) begin
					load_out = 1'b1;
					state_d  = DIV_IDLE;
				end
			end
			default: begin
				state_d = DIV_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DIV_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Restoring division, quotient known to fit MEAN_W bits
	always_ff @(posedge clk) begin
		if (pop) begin
			rem_x_q <= pop_data.sum_x;
			rem_y_q <= pop_data.sum_y;
			cnt_q   <= pop_data.count;
			dvs_q   <= {pop_data.count, {(MEAN_W - 1){1'b0}}};
			step_q  <= TOP_STEP;
			qx_q    <= '0;
			qy_q    <= '0;
		end else if (state_q == DIV_RUN) begin
			if (ge_x) begin
				rem_x_q <= rem_x_q - dvs_q;
			end
			if (ge_y) begin
				rem_y_q <= rem_y_q - dvs_q;
			end
			qx_q   <= {qx_q[MEAN_W-2:0], ge_x};
			qy_q   <= {qy_q[MEAN_W-2:0], ge_y};
			dvs_q  <= dvs_q >> 1;
			step_q <= step_q - 1'b1;
		end
	end

	// Output stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			found_q  <= nonzero;
			mean_x_q <= nonzero ? qx_q : '0;
			mean_y_q <= nonzero ? qy_q : '0;
		end
	end

	assign result.valid  = out_valid_q;
	assign result.found  = found_q;
	assign result.mean_x = mean_x_q;
	assign result.mean_y = mean_y_q;

	// Checks
	`CBC_ASSERT_IMP(a_rem_below_count, (state_q == DIV_DONE) && nonzero, (rem_x_q < SUM_W'(cnt_q)) && (rem_y_q < SUM_W'(cnt_q)), "division remainder not below count")
	`CBC_ASSERT_IMP(a_step_range, state_q == DIV_RUN, step_q <= TOP_STEP, "divider step out of range")
	`CBC_ASSERT_IMP(a_out_from_done, $rose(out_valid_q), $past(state_q == DIV_DONE), "result loaded outside done state")
	`CBC_ASSERT_NXT(a_pop_starts_run, pop, state_q == DIV_RUN, "pop did not start division")

endmodule

@@ rtl/core/color_blob_centroid_core.sv @@
// Pixels are accepted one per cycle while the frame queue has room; a frame's
// totals pass the queue and the 10-step shared divider loop before the output
// stage registers its result word. The back end finishes one frame before it
// pops the next; a queue of QUEUE_DEPTH frame totals absorbs short frames, and
// pixel ready drops only while that queue is full. Reset (asynchronous, active
// low) clears sums, count, queue and output stage and sets the ratio to 5.
// ---------------------------------------------------------------------------
// color_blob_centroid_core
// Centroid of strongly blue pixels in a pixel stream, one result per frame.
// ---------------------------------------------------------------------------
module color_blob_centroid_core #(
	parameter int QUEUE_DEPTH = cbc_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	cbc_pixel_if.sink                      pixel,
	cbc_result_if.source                   result,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [cbc_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [cbc_pkg::CFG_DATA_W-1:0] pwdata,
	output logic [cbc_pkg::CFG_DATA_W-1:0] prdata,
	output logic                           pready
);
	import cbc_pkg::*;

	logic [RATIO_W-1:0] ratio_q;
	logic               cfg_we;
	logic               push;
	logic               pop;
	frame_sums_t        push_data;
	frame_sums_t        pop_data;
	queue_stat_t        qstat;

	// Register port: word index in paddr[2]
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_RATIO);
	assign prdata = (paddr[2] == REG_RATIO) ? CFG_DATA_W'(ratio_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ratio_q <= RATIO_RESET;
		end else if (cfg_we) begin
			ratio_q <= pwdata[RATIO_W-1:0];
		end
	end

	// Front: classify and accumulate
	cbc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.pixel     (pixel),
		.ratio     (ratio_q),
		.qstat     (qstat),
		.push      (push),
		.push_data (push_data)
	);

	// Queue of frame totals
	cbc_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.stat      (qstat)
	);

	// Back: divide and present result
	cbc_divider u_divider (
		.clk      (clk),
		.arst_n   (arst_n),
		.qstat    (qstat),
		.pop_data (pop_data),
		.pop      (pop),
		.result   (result)
	);

endmodule
